@@ rtl/rld_pkg.sv @@
`default_nettype none

package rld_pkg;

    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned CountWidth = 16;

    // Control codes above this value announce a run; others a literal group.
    localparam logic [ByteWidth-1:0] RunBase   = 8'h80;
    // Run length is code minus this value (2..128).
    localparam logic [ByteWidth-1:0] RunOffset = 8'h7F;

    typedef struct packed {
        logic [ByteWidth-1:0] in_byte;
        logic                 start_image;
    } in_item_t;

    typedef struct packed {
        logic [ByteWidth-1:0] out_byte;
        logic [ByteWidth-1:0] repeat_count;
        logic                 last_of_image;
        logic                 truncated;
    } out_item_t;

    typedef enum logic [3:0] {
        PH_DONE = 4'b0001,
        PH_CTRL = 4'b0010,
        PH_LIT  = 4'b0100,
        PH_RUN  = 4'b1000
    } phase_t;

endpackage : rld_pkg

`default_nettype wire

@@ rtl/rld_in_reg.sv @@
`default_nettype none

module rld_in_reg
    import rld_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_data,
    output logic          item_valid,
    input  wire logic     item_take,
    output in_item_t      item_data
);

    logic     valid_reg;
    in_item_t data_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

endmodule : rld_in_reg

`default_nettype wire

@@ rtl/rld_out_reg.sv @@
`default_nettype none

module rld_out_reg
    import rld_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      res_valid,
    output logic           res_ready,
    input  wire out_item_t res_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    logic      valid_reg;
    out_item_t data_reg;

    assign res_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res_data;
        end
    end

endmodule : rld_out_reg

`default_nettype wire

@@ rtl/rld_core.sv @@
`default_nettype none

module rld_core
    import rld_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CountWidth-1:0] cfg_wr_data,
    input  wire logic                  item_valid,
    output logic                       item_take,
    input  wire in_item_t              item_data,
    output logic                       res_valid,
    input  wire logic                  res_ready,
    output out_item_t                  res_data
);

    logic [CountWidth-1:0] image_bytes_reg;
    phase_t                phase_reg, phase_next;
    logic [ByteWidth-1:0]  literals_left_reg, literals_left_next;
    logic [ByteWidth-1:0]  run_length_reg, run_length_next;
    logic [CountWidth-1:0] bytes_left_reg, bytes_left_next;

    logic                  emit;
    logic [ByteWidth-1:0]  cnt;
    logic [CountWidth-1:0] bl_after;
    logic                  last;
    logic                  trunc;
    logic [ByteWidth-1:0]  b;

    assign item_take = item_valid && res_ready;
    assign b         = item_data.in_byte;

    always_comb
    begin
        phase_next         = phase_reg;
        literals_left_next = literals_left_reg;
        run_length_next    = run_length_reg;
        bytes_left_next    = bytes_left_reg;
        emit               = 1'b0;
        cnt                = 8'd1;
        bl_after           = bytes_left_reg - 16'd1;
        last               = 1'b0;
        trunc              = 1'b0;

        if (item_data.start_image)
        begin
            bytes_left_next    = image_bytes_reg;
            literals_left_next = '0;
            run_length_next    = '0;
            if (image_bytes_reg == '0)
            begin
                phase_next = PH_DONE;
            end
            else if (b > RunBase)
            begin
                run_length_next = b - RunOffset;
                phase_next      = PH_RUN;
            end
            else
            begin
                literals_left_next = b;
                phase_next         = PH_LIT;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_CTRL:
                begin
                    if (b > RunBase)
                    begin
                        run_length_next = b - RunOffset;
                        phase_next      = PH_RUN;
                    end
                    else
                    begin
                        literals_left_next = b;
                        phase_next         = PH_LIT;
                    end
                end
                PH_LIT:
                begin
                    emit            = 1'b1;
                    bl_after        = bytes_left_reg - 16'd1;
                    bytes_left_next = bl_after;
                    last            = (bl_after == '0);
                    trunc           = last && (literals_left_reg != '0);
                    if (last)
                    begin
                        phase_next         = PH_DONE;
                        literals_left_next = '0;
                    end
                    else if (literals_left_reg == '0)
                    begin
                        phase_next = PH_CTRL;
                    end
                    else
                    begin
                        literals_left_next = literals_left_reg - 8'd1;
                    end
                end
                PH_RUN:
                begin
                    emit = 1'b1;
                    if ({8'd0, run_length_reg} > bytes_left_reg)
                    begin
                        // bytes_left is below the run length here, so it fits in a byte
                        cnt   = bytes_left_reg[ByteWidth-1:0];
                        trunc = 1'b1;
                    end
                    else
                    begin
                        cnt = run_length_reg;
                    end
                    bl_after        = bytes_left_reg - {8'd0, cnt};
                    bytes_left_next = bl_after;
                    last            = (bl_after == '0);
                    phase_next      = last ? PH_DONE : PH_CTRL;
                    run_length_next = '0;
                end
                default:
                begin
                    // done: byte dropped
                end
            endcase
        end
    end

    assign res_valid              = item_valid && emit;
    assign res_data.out_byte      = b;
    assign res_data.repeat_count  = cnt;
    assign res_data.last_of_image = last;
    assign res_data.truncated     = trunc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_bytes_reg   <= '0;
            phase_reg         <= PH_DONE;
            literals_left_reg <= '0;
            run_length_reg    <= '0;
            bytes_left_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                image_bytes_reg <= cfg_wr_data;
            end
            if (item_take)
            begin
                phase_reg         <= phase_next;
                literals_left_reg <= literals_left_next;
                run_length_reg    <= run_length_next;
                bytes_left_reg    <= bytes_left_next;
            end
        end
    end

    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !item_data.start_image && (phase_reg == PH_LIT || phase_reg == PH_RUN))
        else $error("result from a phase that takes no data byte");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.truncated |-> res_data.last_of_image)
        else $error("truncated result does not close the image");

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |-> bytes_left_reg == '0)
        else $error("done phase with bytes still owed");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.repeat_count != '0)
        else $error("result with zero repeat count");

    a_last_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        item_take && res_valid && res_data.last_of_image |=> phase_reg == PH_DONE)
        else $error("image completed but phase not done");

endmodule : rld_core

`default_nettype wire

@@ rtl/run_length_byte_decoder.sv @@
// Path: a result is registered in the output register after its input transfer has passed
//   the input register and then the decode logic.
// Throughput: one compressed byte per cycle while the output register can take a result;
//   the byte-budget and phase update is a single pass of 16-bit subtract/compare logic.
// Reset (rst_n, async, active low): image size 0, phase done, both stages empty.
// Control bytes and dropped bytes are consumed without a result.
`default_nettype none

module run_length_byte_decoder
    import rld_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // image size register write
    input  wire logic                  cfg_wr_en,
    input  wire logic [CountWidth-1:0] cfg_wr_data,

    // compressed byte stream
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,

    // decoded byte/count stream
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data
);

    // input register -> decode
    logic      item_valid;
    logic      item_take;
    in_item_t  item_data;

    // decode -> output register
    logic      res_valid;
    logic      res_ready;
    out_item_t res_data;

    // Input stage: takes a transfer whenever empty or draining this cycle.
    rld_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item_data  (item_data)
    );

    // Decode: phase, literal/run counters and byte budget live here. A byte
    // is consumed only when the output register can take whatever it yields.
    rld_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_take   (item_take),
        .item_data   (item_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data)
    );

    // Output stage: holds a finished result while the next byte is decoded.
    rld_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule : run_length_byte_decoder

`default_nettype wire
